// ===== src/nnfs_pkg.sv =====
// Shared widths, register indexes and item codes for the nearest neighbour frame scaler.
// No dependencies; the divider, the line store and the top level import it.
package nnfs_pkg;

  // Field and datapath widths
  localparam int PIX_W  = 24;             // packed red, green, blue
  localparam int ROW_W  = 11;             // source row tag
  localparam int SRCW_W = 12;             // source dimension registers
  localparam int DIM_W  = 13;             // clamped dimensions, display registers
  localparam int POS_W  = 13;             // destination column and line counters
  localparam int QUO_W  = 12;             // source column or row from one division
  localparam int PROD_W = POS_W + DIM_W;  // position times source dimension
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 13;

  // Dimension limits
  localparam int DEF_MAX_SRC_WIDTH = 2048;
  localparam int MAX_SRC_HEIGHT    = 2048;
  localparam int MAX_DST_DIM       = 4096;

  // Test pattern geometry
  localparam int BORDER      = 3;
  localparam int GRID_X_BITS = 6;   // vertical grid line every 64 columns
  localparam int GRID_Y_BITS = 5;   // horizontal grid line every 32 lines

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEST_PATTERN = 3'd4;

  // Input word actions
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EMIT = 1'b1;

endpackage

// ===== src/nnfs_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, for scaled coordinates.
// Depends on nnfs_pkg for the product, divisor and quotient widths.
module nnfs_div import nnfs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [PROD_W-1:0] dividend_i,
  input  logic [DIM_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [QUO_W-1:0]  quotient_o
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [PROD_W-1:0] rem_q, rem_d;
  logic [PROD_W-1:0] dsh_q, dsh_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic              ge;

  // One compare and subtract against the shifted divisor per step
  assign ge = rem_q >= dsh_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(QUO_W);
      rem_d  = dividend_i;
      dsh_d  = PROD_W'(divisor_i) << (QUO_W - 1);
      quo_d  = '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - dsh_q;
      end
      quo_d = {quo_q[QUO_W-2:0], ge};
      dsh_d = dsh_q >> 1;
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== src/nnfs_line_store.sv =====
// One-line pixel store: synchronous RAM, one write and one registered read port.
// Depends on nnfs_pkg for the pixel width.
module nnfs_line_store import nnfs_pkg::*; #(
  parameter int DEPTH = DEF_MAX_SRC_WIDTH,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [PIX_W-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [PIX_W-1:0] rd_data_o
);

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/nearest_neighbor_frame_scaler.sv =====
// Nearest neighbour frame scaler: top level with sequencer, counters and output register.
// Depends on nnfs_pkg, nnfs_div and nnfs_line_store.
//
// A load word writes one source pixel into the line store at the running load column
// (a new row tag restarts at column 0) and leaves the sequencer in idle. An emit word
// starts the divisions, waits for the three parallel 12-step restoring dividers (source
// column, needed row, next row) and their done flags, reads the line store, loads the
// output register once that register is free or being read, and returns to idle; only
// then is the next word accepted. A finished result waits in the output register
// while the next word is accepted and worked on. The display size and source size
// registers are clamped to their limits on use, and zero is taken as one.
module nearest_neighbor_frame_scaler import nnfs_pkg::*; #(
  parameter int MAX_SRC_WIDTH = DEF_MAX_SRC_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  // input word channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 action_i,
  input  logic [7:0]           red_i,
  input  logic [7:0]           green_i,
  input  logic [7:0]           blue_i,
  input  logic [ROW_W-1:0]     source_row_i,
  // result word channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [PIX_W-1:0]     pixel_word_o,
  output logic                 row_end_o,
  output logic                 frame_end_o,
  output logic [ROW_W-1:0]     next_source_row_o,
  output logic                 row_stale_o
);

  localparam int AW = $clog2(MAX_SRC_WIDTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  // Dimension clamp: zero reads as one, anything above the limit as the limit
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W:0]   hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if ({1'b0, v} > hi) begin
      r = hi[DIM_W-1:0];
    end
    return r;
  endfunction

  // Ramps shifted by the frame phase, white grid, red border
  function automatic logic [PIX_W-1:0] pattern_pixel(input logic [POS_W-1:0] x,
                                                     input logic [POS_W-1:0] y,
                                                     input logic [DIM_W-1:0] dw,
                                                     input logic [DIM_W-1:0] dh,
                                                     input logic [7:0]       fc);
    logic [7:0] phase, r, g, b;
    phase = fc + {fc[6:0], 1'b0};
    r = x[7:0] + phase;
    g = {y[6:0], 1'b0} + phase;
    b = (x[7:0] ^ y[7:0]) + phase;
    if (x[GRID_X_BITS-1:0] == '0 || y[GRID_Y_BITS-1:0] == '0) begin
      r = 8'hFF;
      g = 8'hFF;
      b = 8'hFF;
    end
    if (x < POS_W'(BORDER) || y < POS_W'(BORDER) ||
        ({1'b0, x} + (POS_W+1)'(BORDER)) >= {1'b0, dw} ||
        ({1'b0, y} + (POS_W+1)'(BORDER)) >= {1'b0, dh}) begin
      r = 8'hFF;
      g = 8'h00;
      b = 8'h00;
    end
    return {r, g, b};
  endfunction

  // Configuration registers
  logic [SRCW_W-1:0] src_w_q, src_h_q;
  logic [DIM_W-1:0]  dst_w_q, dst_h_q;
  logic              tp_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= SRCW_W'(320);
      src_h_q <= SRCW_W'(240);
      dst_w_q <= DIM_W'(1280);
      dst_h_q <= DIM_W'(960);
      tp_q    <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_SRC_WIDTH:    src_w_q <= cfg_data_i[SRCW_W-1:0];
        CFG_SRC_HEIGHT:   src_h_q <= cfg_data_i[SRCW_W-1:0];
        CFG_DST_WIDTH:    dst_w_q <= cfg_data_i;
        CFG_DST_HEIGHT:   dst_h_q <= cfg_data_i;
        CFG_TEST_PATTERN: tp_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Clamped dimensions
  logic [DIM_W-1:0] sw, sh, dw, dh;
  assign sw = clamp_dim(DIM_W'(src_w_q), (DIM_W+1)'(MAX_SRC_WIDTH));
  assign sh = clamp_dim(DIM_W'(src_h_q), (DIM_W+1)'(MAX_SRC_HEIGHT));
  assign dw = clamp_dim(dst_w_q, (DIM_W+1)'(MAX_DST_DIM));
  assign dh = clamp_dim(dst_h_q, (DIM_W+1)'(MAX_DST_DIM));

  // State
  logic [2:0]       state_q, state_d;
  logic [AW-1:0]    load_col_q, load_col_d;
  logic [ROW_W-1:0] loaded_row_q;
  logic [POS_W-1:0] out_col_q, out_col_d;
  logic [POS_W-1:0] out_line_q, out_line_d;
  logic [7:0]       frame_cnt_q, frame_cnt_d;

  logic in_fire, load_fire, emit_fire;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign load_fire  = in_fire && (action_i == ACT_LOAD);
  assign emit_fire  = in_fire && (action_i == ACT_EMIT);

  // Load column: restart on a new row tag, wrap after the last source column
  logic [AW-1:0]    col_base, col_wr;
  logic [DIM_W:0]   col_inc;
  assign col_base = (source_row_i != loaded_row_q) ? '0 : load_col_q;
  assign col_wr   = ((DIM_W+1)'(col_base) >= {1'b0, sw}) ? '0 : col_base;
  assign col_inc  = (DIM_W+1)'(col_wr) + (DIM_W+1)'(1);
  assign load_col_d = (col_inc >= {1'b0, sw}) ? '0 : AW'(col_inc);

  // Dividers: source column, needed row, next row
  logic              div_start;
  logic [POS_W-1:0]  line_inc;
  logic [PROD_W-1:0] prod_sx, prod_need, prod_next;
  logic              done_sx, done_need, done_next;
  logic [QUO_W-1:0]  q_sx, q_need, q_next;

  assign div_start = (state_q == S_START);
  assign line_inc  = out_line_q + POS_W'(1);
  assign prod_sx   = out_col_q * sw;
  assign prod_need = out_line_q * sh;
  assign prod_next = line_inc * sh;

  nnfs_div u_div_sx (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(prod_sx), .divisor_i(dw),
    .done_o(done_sx), .quotient_o(q_sx)
  );
  nnfs_div u_div_need (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(prod_need), .divisor_i(dh),
    .done_o(done_need), .quotient_o(q_need)
  );
  nnfs_div u_div_next (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(prod_next), .divisor_i(dh),
    .done_o(done_next), .quotient_o(q_next)
  );

  // Coordinates past a shrunk frame take the last source column or row
  logic [QUO_W-1:0] sx_sel, need_sel, next_sel;
  assign sx_sel   = (out_col_q < dw)  ? q_sx   : QUO_W'(sw - DIM_W'(1));
  assign need_sel = (out_line_q < dh) ? q_need : QUO_W'(sh - DIM_W'(1));

  // Line store
  logic             rd_en;
  logic [PIX_W-1:0] rd_data;
  assign rd_en = (state_q == S_READ);

  nnfs_line_store #(.DEPTH(MAX_SRC_WIDTH)) u_store (
    .clk_i,
    .wr_en_i   (load_fire),
    .wr_addr_i (col_wr),
    .wr_data_i ({red_i, green_i, blue_i}),
    .rd_en_i   (rd_en),
    .rd_addr_i (AW'(sx_sel)),
    .rd_data_o (rd_data)
  );

  // Result assembly
  logic             row_end_d, frame_end_d, stale_d, out_load;
  logic [PIX_W-1:0] pix_d;
  assign row_end_d   = ({1'b0, out_col_q} + (POS_W+1)'(1)) >= {1'b0, dw};
  assign frame_end_d = row_end_d && (({1'b0, out_line_q} + (POS_W+1)'(1)) >= {1'b0, dh});
  assign next_sel    = !row_end_d ? need_sel : (frame_end_d ? '0 : q_next);
  assign stale_d     = !tp_q && ({1'b0, loaded_row_q} != need_sel);
  assign pix_d       = tp_q ? pattern_pixel(out_col_q, out_line_q, dw, dh, frame_cnt_q)
                            : rd_data;
  assign out_load    = (state_q == S_OUT) && (!out_valid_o || out_ready_i);

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (emit_fire) state_d = S_START;
      S_START: state_d = S_DIV;
      S_DIV:   if (done_sx && done_need && done_next) state_d = S_READ;
      S_READ:  state_d = S_OUT;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Raster position and frame counter advance when the result loads the output register
  always_comb begin
    out_col_d   = out_col_q;
    out_line_d  = out_line_q;
    frame_cnt_d = frame_cnt_q;
    if (out_load) begin
      if (row_end_d) begin
        out_col_d = '0;
        if (frame_end_d) begin
          out_line_d  = '0;
          frame_cnt_d = frame_cnt_q + 8'd1;
        end else begin
          out_line_d = line_inc;
        end
      end else begin
        out_col_d = out_col_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      load_col_q   <= '0;
      loaded_row_q <= '0;
      out_col_q    <= '0;
      out_line_q   <= '0;
      frame_cnt_q  <= '0;
    end else begin
      state_q     <= state_d;
      out_col_q   <= out_col_d;
      out_line_q  <= out_line_d;
      frame_cnt_q <= frame_cnt_d;
      if (load_fire) begin
        load_col_q   <= load_col_d;
        loaded_row_q <= source_row_i;
      end
    end
  end

  // Output register
  logic             out_valid_q;
  logic [PIX_W-1:0] pixel_q;
  logic             row_end_q, frame_end_q, stale_q;
  logic [ROW_W-1:0] next_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pixel_q     <= pix_d;
      row_end_q   <= row_end_d;
      frame_end_q <= frame_end_d;
      next_row_q  <= ROW_W'(next_sel);
      stale_q     <= stale_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign pixel_word_o      = pixel_q;
  assign row_end_o         = row_end_q;
  assign frame_end_o       = frame_end_q;
  assign next_source_row_o = next_row_q;
  assign row_stale_o       = stale_q;

  // Checks
  a_frame_end_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> row_end_o)
    else $error("frame end word without row end");

  a_frame_end_row_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> next_source_row_o == '0)
    else $error("frame end word does not point back at row zero");

  a_load_keeps_raster: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_fire |=> $stable(out_col_q) && $stable(out_line_q))
    else $error("load word moved the raster position");

  a_read_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |-> $past(state_q) == S_DIV)
    else $error("line store read issued before the divisions finished");

  a_row_end_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && row_end_d |=> out_col_q == '0)
    else $error("column did not wrap after a row end");

endmodule

// ===== verif/nearest_neighbor_frame_scaler_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for nearest_neighbor_frame_scaler: directed and random load and
// emit words, each result word checked against a scoreboard that predicts the pixel.
// Depends on nnfs_pkg and the scaler RTL.
module nearest_neighbor_frame_scaler_tb;
  import nnfs_pkg::*;

  localparam int QUIET_LIMIT  = 2000;  // cycles without any accepted word
  localparam int HOLD_CYCLES  = 300;   // one long receiver hold-off
  localparam int DRAIN_CYCLES = 40;    // quiet time after the last result word
  localparam int RANDOM_ITEMS = 150;
  localparam int MAX_REPORTS  = 10;
  localparam int ROW_MAX      = (1 << ROW_W) - 1;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             row_end;
    logic             frame_end;
    logic [ROW_W-1:0] next_row;
    logic             stale;
  } result_t;

  // Scoreboard: own copy of registers, line store and raster position
  class scaler_scoreboard;
    logic [SRCW_W-1:0] src_w_reg, src_h_reg;
    logic [DIM_W-1:0]  dst_w_reg, dst_h_reg;
    logic              pattern_on;
    logic [PIX_W-1:0]  line_mem [DEF_MAX_SRC_WIDTH];
    bit                written  [DEF_MAX_SRC_WIDTH];
    int unsigned       load_col, cur_row, col_pos, line_pos;
    logic [7:0]        frame_cnt;
    result_t           awaited_pixels[$];
    int                mismatches;

    function new();
      src_w_reg  = 12'd320;
      src_h_reg  = 12'd240;
      dst_w_reg  = 13'd1280;
      dst_h_reg  = 13'd960;
      pattern_on = 1'b0;
      foreach (written[i]) begin
        written[i]  = 1'b0;
        line_mem[i] = '0;
      end
      load_col   = 0;
      cur_row    = 0;
      col_pos    = 0;
      line_pos   = 0;
      frame_cnt  = '0;
      mismatches = 0;
    endfunction

    // zero reads as one, oversize reads as the limit
    function int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
    endfunction

    function int unsigned eff_sw();
      return clamp_dim(src_w_reg, DEF_MAX_SRC_WIDTH);
    endfunction

    function int unsigned eff_sh();
      return clamp_dim(src_h_reg, MAX_SRC_HEIGHT);
    endfunction

    function int unsigned eff_dw();
      return clamp_dim(dst_w_reg, MAX_DST_DIM);
    endfunction

    function int unsigned eff_dh();
      return clamp_dim(dst_h_reg, MAX_DST_DIM);
    endfunction

    // source row the current destination line samples
    function int unsigned need_row();
      int unsigned sh, dh;
      sh = eff_sh();
      dh = eff_dh();
      return (line_pos < dh) ? line_pos * sh / dh : sh - 1;
    endfunction

    function int unsigned cols_to_row_end();
      int unsigned dw;
      dw = eff_dw();
      return (col_pos < dw) ? dw - col_pos : 1;
    endfunction

    // every column a scaled pixel can read has been loaded
    function bit store_ready();
      int unsigned sw;
      sw = eff_sw();
      for (int i = 0; i < sw; i++)
        if (!written[i]) return 1'b0;
      return 1'b1;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        CFG_SRC_WIDTH:    src_w_reg  = data[SRCW_W-1:0];
        CFG_SRC_HEIGHT:   src_h_reg  = data[SRCW_W-1:0];
        CFG_DST_WIDTH:    dst_w_reg  = data[DIM_W-1:0];
        CFG_DST_HEIGHT:   dst_h_reg  = data[DIM_W-1:0];
        CFG_TEST_PATTERN: pattern_on = data[0];
        default: ;
      endcase
    endfunction

    // ramps shifted by frame phase, white grid, red border three pixels deep
    function logic [PIX_W-1:0] pattern_colour(int unsigned x, y, dw, dh);
      int unsigned phase, r, g, b;
      phase = (int'(frame_cnt) * 3) & 'hFF;
      r = (x + phase) & 'hFF;
      g = (y * 2 + phase) & 'hFF;
      b = ((x ^ y) + phase) & 'hFF;
      if (x % (1 << GRID_X_BITS) == 0 || y % (1 << GRID_Y_BITS) == 0) begin
        r = 255;
        g = 255;
        b = 255;
      end
      if (x < BORDER || y < BORDER || x + BORDER >= dw || y + BORDER >= dh) begin
        r = 255;
        g = 0;
        b = 0;
      end
      return {r[7:0], g[7:0], b[7:0]};
    endfunction

    // accepted input word: loads update the store, emits queue a result
    function void note_input(logic act, logic [7:0] r, g, b, logic [ROW_W-1:0] row);
      result_t     want;
      int unsigned sw, sh, dw, dh, x, y, need, sx, nxt;
      bit          rend, fend;
      sw = eff_sw();
      sh = eff_sh();
      dw = eff_dw();
      dh = eff_dh();
      if (act == ACT_LOAD) begin
        if (row != cur_row) begin
          cur_row  = row;
          load_col = 0;
        end
        if (load_col >= sw) load_col = 0;
        line_mem[load_col] = {r, g, b};
        written[load_col]  = 1'b1;
        load_col++;
        if (load_col >= sw) load_col = 0;
        return;
      end
      x    = col_pos;
      y    = line_pos;
      rend = (x + 1 >= dw);
      fend = rend && (y + 1 >= dh);
      need = need_row();
      want.stale = 1'b0;
      if (pattern_on) begin
        want.pixel = pattern_colour(x, y, dw, dh);
      end else begin
        sx = (x < dw) ? x * sw / dw : sw - 1;
        want.pixel = line_mem[sx];
        want.stale = (cur_row != need);
      end
      want.next_row = need[ROW_W-1:0];
      if (rend) begin
        col_pos = 0;
        if (fend) begin
          line_pos  = 0;
          frame_cnt = frame_cnt + 8'd1;
          want.next_row = '0;
        end else begin
          line_pos = y + 1;
          nxt = (y + 1) * sh / dh;
          want.next_row = nxt[ROW_W-1:0];
        end
      end else begin
        col_pos = x + 1;
      end
      want.row_end   = rend;
      want.frame_end = fend;
      awaited_pixels.push_back(want);
    endfunction

    // accepted result word against the oldest prediction
    function void check_result(result_t got);
      result_t want;
      if (awaited_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result word with nothing outstanding: %h", $time, got);
        return;
      end
      want = awaited_pixels.pop_front();
      if (got.pixel !== want.pixel || got.row_end !== want.row_end ||
          got.frame_end !== want.frame_end || got.next_row !== want.next_row ||
          got.stale !== want.stale) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: expected pixel %h row_end %b frame_end %b next_row %0d stale %b",
                   $time, want.pixel, want.row_end, want.frame_end, want.next_row,
                   want.stale);
          $display("%0t:      got pixel %h row_end %b frame_end %b next_row %0d stale %b",
                   $time, got.pixel, got.row_end, got.frame_end, got.next_row, got.stale);
        end
      end
    endfunction
  endclass

  logic                 clk, rst_n;
  logic                 cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;
  logic                 in_valid, in_ready, action;
  logic [7:0]           red, green, blue;
  logic [ROW_W-1:0]     source_row;
  logic                 out_valid, out_ready;
  logic [PIX_W-1:0]     pixel_word;
  logic                 row_end, frame_end, row_stale;
  logic [ROW_W-1:0]     next_source_row;

  scaler_scoreboard sb;
  int unsigned      sent_items = 0;
  int               tx_mode = 1;
  int               rx_mode = 1;
  bit               hold_req = 1'b0;

  nearest_neighbor_frame_scaler u_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .action_i          (action),
    .red_i             (red),
    .green_i           (green),
    .blue_i            (blue),
    .source_row_i      (source_row),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .pixel_word_o      (pixel_word),
    .row_end_o         (row_end),
    .frame_end_o       (frame_end),
    .next_source_row_o (next_source_row),
    .row_stale_o       (row_stale)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // mostly short gaps, now and then a long one; mode 0 never idles
  function automatic int pick_gap(int mode);
    int r;
    if (mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one input word; valid stays up across back-to-back words
  task automatic send_item(logic act, logic [7:0] r, g, b, logic [ROW_W-1:0] row);
    int gap;
    gap = pick_gap(tx_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    red        <= r;
    green      <= g;
    blue       <= b;
    source_row <= row;
    do @(posedge clk); while (!in_ready);
    sb.note_input(act, r, g, b, row);
    sent_items++;
  endtask

  task automatic load_random(int unsigned row);
    send_item(ACT_LOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), row[ROW_W-1:0]);
  endtask

  task automatic emit_pixels(int n);
    repeat (n)
      send_item(ACT_EMIT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), ROW_W'($urandom_range(0, ROW_MAX)));
  endtask

  // a full source line: wrap-around covers every column once
  task automatic load_source_row(int unsigned row);
    repeat (sb.eff_sw()) load_random(row);
  endtask

  task automatic add_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0:       load_random($urandom_range(0, ROW_MAX));
        1:       load_random(sb.cur_row);
        default: emit_pixels(1);
      endcase
    end
  endtask

  // config write; valid is lowered by the caller after the last one
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DAT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, value[CFG_DAT_W-1:0]);
  endtask

  task automatic configure(int unsigned sw, sh, dw, dh, logic tp);
    write_reg(CFG_SRC_WIDTH, sw);
    write_reg(CFG_SRC_HEIGHT, sh);
    write_reg(CFG_DST_WIDTH, dw);
    write_reg(CFG_DST_HEIGHT, dh);
    write_reg(CFG_TEST_PATTERN, 32'(tp));
    cfg_valid <= 1'b0;
  endtask

  // drop valid, wait for every result, then let the datapath go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.awaited_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one setting: mostly load-the-needed-line-then-emit-a-row, some noise
  task automatic run_phase(int unsigned sw, sh, dw, dh, logic tp, int rows, bit noisy,
                           bit hold);
    settle();
    configure(sw, sh, dw, dh, tp);
    tx_mode = hold ? 0 : int'($urandom_range(0, 3) != 0);
    rx_mode = int'($urandom_range(0, 3) != 0);
    hold_req = hold;
    if (!tp && !sb.store_ready()) load_source_row(sb.need_row());
    repeat (rows) begin
      if (noisy && $urandom_range(0, 99) < 20) begin
        add_noise();
      end else begin
        if (!tp && (sb.cur_row != sb.need_row() || $urandom_range(0, 3) == 0))
          load_source_row(sb.need_row());
        emit_pixels(sb.cols_to_row_end());
      end
    end
  endtask

  // result side: random stalls plus the one long hold-off
  initial begin : receiver
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = pick_gap(rx_mode);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result({pixel_word, row_end, frame_end, next_source_row, row_stale});
  end

  // give up after a long stretch with no word moving on any channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int unsigned random_base, sw_v, sh_v, dw_v, dh_v;
    int          rows;
    logic        tp_v;
    sb = new();
    rst_n      <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    action     <= ACT_LOAD;
    red        <= '0;
    green      <= '0;
    blue       <= '0;
    source_row <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // small scaled frame: colour extremes, load wrap, row end
    configure(4, 3, 6, 4, 1'b0);
    send_item(ACT_LOAD, 8'h00, 8'h00, 8'h00, '0);
    send_item(ACT_LOAD, 8'hFF, 8'hFF, 8'hFF, '0);
    send_item(ACT_LOAD, 8'h5A, 8'hA5, 8'h0F, '0);
    send_item(ACT_LOAD, 8'hF0, 8'h3C, 8'hC3, '0);
    // fifth pixel on the same row lands back in column 0
    send_item(ACT_LOAD, 8'h01, 8'h80, 8'h7F, '0);
    emit_pixels(6);
    // top row tag restarts the line and leaves it stale
    send_item(ACT_LOAD, 8'hFF, 8'h00, 8'hFF, ROW_MAX[ROW_W-1:0]);
    emit_pixels(2);
    settle();
    // pattern on a display narrower than two borders
    configure(4, 3, 5, 4, 1'b1);
    emit_pixels(4);
    settle();
    // shrink below the running position; zero sizes read as one
    configure(0, 0, 1, 1, 1'b0);
    emit_pixels(2);
    settle();
    // oversize register values clamp to the limits
    configure(4095, 4095, 8191, 8191, 1'b1);
    emit_pixels(2);

    random_base = sent_items;
    // wide pattern rows reach the vertical grid line; receiver holds off meanwhile
    run_phase(4, 4, 68, 7, 1'b1, 4, 1'b0, 1'b1);
    // tall pattern frame reaches the horizontal grid line and wraps the frame
    run_phase(4, 40, 7, 36, 1'b1, 34, 1'b0, 1'b0);
    random_base = sent_items;

    // random small settings, with the odd zero or oversize value
    while (sent_items - random_base < RANDOM_ITEMS) begin
      sw_v = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
      case ($urandom_range(0, 19))
        0:       sh_v = 0;
        1:       sh_v = 4095;
        default: sh_v = $urandom_range(1, 8);
      endcase
      dw_v = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
      case ($urandom_range(0, 19))
        0:       dh_v = 0;
        1:       dh_v = 8191;
        default: dh_v = $urandom_range(1, 10);
      endcase
      tp_v = ($urandom_range(0, 3) == 0);
      rows = $urandom_range(1, 6);
      run_phase(sw_v, sh_v, dw_v, dh_v, tp_v, rows, 1'b1, 1'b0);
    end

    // wider source line in scaled mode under oversize height and display sizes
    run_phase(64, 4095, 8191, 8191, 1'b0, 0, 1'b0, 1'b0);
    emit_pixels(24);

    settle();
    if (sb.mismatches == 0 && sb.awaited_pixels.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== nearest_neighbor_frame_scaler.f =====
src/nnfs_pkg.sv
src/nnfs_div.sv
src/nnfs_line_store.sv
src/nearest_neighbor_frame_scaler.sv
verif/nearest_neighbor_frame_scaler_tb.sv
